FILE: sv/slir_pkg.sv
package slir_pkg;

   // Widths fixed by the channel payloads
   localparam int VALUE_BITS  = 32;
   localparam int OPCODE_BITS = 2;
   localparam int POS_BITS    = 4;
   localparam int STATUS_BITS = 3;
   localparam int COUNT_BITS  = 5;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } slir_opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_BAD_POS   = 3'd4
   } slir_status_type;

   typedef struct packed {
      logic [OPCODE_BITS-1:0]       opcode;
      logic signed [VALUE_BITS-1:0] value;
      logic [POS_BITS-1:0]          position;
   } slir_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]       status;
      logic signed [VALUE_BITS-1:0] read_value;
      logic [COUNT_BITS-1:0]        count;
   } slir_rsp_type;

   // Shift command broadcast to every cell
   typedef struct packed {
      logic insert_go;
      logic remove_go;
   } slir_cmd_type;

   // Flags one cell reports to its right neighbor and to the top level
   typedef struct packed {
      logic after;   // cell lies at or past the insertion point
      logic match;   // cell holds a live entry equal to the key
   } slir_flags_type;

endpackage

FILE: sv/slir_cell.sv
module slir_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  slir_pkg::slir_cmd_type        cmd,
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic                          live,
   input  logic                          left_after,
   input  logic signed [VALUE_WIDTH-1:0] left_value,
   input  logic signed [VALUE_WIDTH-1:0] right_value,
   output logic signed [VALUE_WIDTH-1:0] entry,
   output slir_pkg::slir_flags_type      flags
);
   import slir_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;
   logic                          ge_key;

   // Compare the held entry against the broadcast key
   assign ge_key      = live && (value_ff >= key);
   assign flags.after = !live || (value_ff > key);
   assign flags.match = live && (value_ff == key);
   assign entry       = value_ff;

   // Take the key, shift up from the left, shift down from the right, or hold
   always_comb begin
      value_in = value_ff;
      if (cmd.insert_go && flags.after) begin
         value_in = left_after ? left_value : key;
      end else if (cmd.remove_go && ge_key) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: sv/sorted_list_insert_remove_unit.sv
// Channel   Direction  Payload        Transfer when
// req_      in         slir_req_type  req_valid && !req_stall
// rsp_      out        slir_rsp_type  rsp_valid && !rsp_stall
//
// For every operation the row of cells compares the key in
// parallel and shifts at the edge that also registers the result.
// One item per cycle is sustained while rsp_stall stays low.
// A held result stalls the request side until it is transferred.
// Reset empties the list at once; entries are never cleared.
module sorted_list_insert_remove_unit #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  slir_pkg::slir_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slir_pkg::slir_rsp_type rsp_data
);
   import slir_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > POS_BITS) ? CW : POS_BITS;

   logic [CW-1:0]                 count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   slir_rsp_type                  rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic signed [VALUE_WIDTH-1:0] key;
   logic signed [VALUE_WIDTH-1:0] entry_q [DEPTH];
   slir_flags_type                flags_q [DEPTH];
   logic [DEPTH-1:0]              live_q;
   logic [DEPTH-1:0]              sel_q;
   logic [DEPTH-1:0]              match_q;
   slir_cmd_type                  cmd;
   logic                          full, empty, found, read_ok;
   logic signed [VALUE_WIDTH-1:0] picked;
   logic signed [VALUE_BITS-1:0]  picked_out;

   // Hold the request side while a result waits
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Bring the request value to the stored width
   if (VALUE_WIDTH <= VALUE_BITS) begin : g_key_narrow
      assign key = req_data.value[VALUE_WIDTH-1:0];
   end else begin : g_key_wide
      assign key = {{(VALUE_WIDTH - VALUE_BITS){1'b0}}, req_data.value};
   end

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign found   = |match_q;
   assign read_ok = MW'(req_data.position) < MW'(count_ff);

   assign cmd.insert_go = accept && (req_data.opcode == OP_INSERT) && !full;
   assign cmd.remove_go = accept && (req_data.opcode == OP_REMOVE) && found;

   // Row of cells
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic                          left_after;
      logic signed [VALUE_WIDTH-1:0] left_value;
      logic signed [VALUE_WIDTH-1:0] right_value;

      assign live_q[k]  = CW'(k) < count_ff;
      assign sel_q[k]   = live_q[k] && (MW'(req_data.position) == MW'(k));
      assign match_q[k] = flags_q[k].match;

      if (k == 0) begin : g_first
         assign left_after = 1'b0;
         assign left_value = key;
      end else begin : g_mid
         assign left_after = flags_q[k-1].after;
         assign left_value = entry_q[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_value = entry_q[k];
      end else begin : g_inner
         assign right_value = entry_q[k+1];
      end

      slir_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key        (key),
         .live       (live_q[k]),
         .left_after (left_after),
         .left_value (left_value),
         .right_value(right_value),
         .entry      (entry_q[k]),
         .flags      (flags_q[k])
      );
   end

   // Select the addressed entry
   always_comb begin
      picked = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (sel_q[k]) begin
            picked = picked | entry_q[k];
         end
      end
   end

   if (VALUE_WIDTH >= VALUE_BITS) begin : g_out_wide
      assign picked_out = picked[VALUE_BITS-1:0];
   end else begin : g_out_narrow
      assign picked_out = {{(VALUE_BITS - VALUE_WIDTH){picked[VALUE_WIDTH-1]}}, picked};
   end

   // Build the result and the next count
   always_comb begin
      count_in                = count_ff;
      rsp_data_in             = rsp_data_ff;
      rsp_valid_in            = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.status     = STATUS_OK;
         rsp_data_in.read_value = '0;
         case (req_data.opcode)
            OP_INSERT: begin
               if (full) begin
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (empty) begin
                  rsp_data_in.status = STATUS_EMPTY;
               end else if (!found) begin
                  rsp_data_in.status = STATUS_NOT_FOUND;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_READ: begin
               if (read_ok) begin
                  rsp_data_in.read_value = picked_out;
               end else begin
                  rsp_data_in.status = STATUS_BAD_POS;
               end
            end
            default: begin
               rsp_data_in.status = STATUS_OK;
            end
         endcase
         rsp_data_in.count = COUNT_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STATUS_FULL) |->
         (count_ff == CW'(DEPTH)))
      else $error("full status with room left");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_go |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("insert did not advance count");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cmd.remove_go |=> (count_ff == CW'($past(count_ff) - 1'b1)))
      else $error("remove did not drop count");

   a_bad_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK) |->
         (rsp_data_ff.read_value == '0))
      else $error("read value set on failed operation");

endmodule

FILE: test/sorted_list_insert_remove_unit_tb.sv
`timescale 1ns / 1ps

module sorted_list_insert_remove_unit_tb;
   import slir_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   slir_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   slir_rsp_type rsp_data;

   // Stimulus and scoreboard state
   slir_req_type pending_reqs[$];
   slir_rsp_type expected_rsps[$];
   int           idle_pct    = 0;
   int           stall_pct   = 0;
   int           error_count = 0;
   int           cycle_count = 0;
   int           sent_count  = 0;
   int           status_seen[5];
   int           peak_len    = 0;

   // Shadow copy of the sorted list
   logic signed [VALUE_BITS-1:0] list_vals[LIST_DEPTH];
   int                           list_len = 0;

   sorted_list_insert_remove_unit #(
      .DEPTH(LIST_DEPTH),
      .VALUE_WIDTH(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one operation to the shadow list and return the result it gives
   function automatic slir_rsp_type apply_list_op(input slir_req_type req);
      slir_rsp_type                 rsp;
      logic signed [VALUE_BITS-1:0] key;
      int                           idx;
      rsp        = '0;
      rsp.status = STATUS_OK;
      key        = req.value;
      case (req.opcode)
         OP_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               // place after any equal entries
               idx = 0;
               while (idx < list_len && list_vals[idx] <= key) idx++;
               for (int j = list_len; j > idx; j--) list_vals[j] = list_vals[j-1];
               list_vals[idx] = key;
               list_len++;
            end
         end
         OP_REMOVE: begin
            if (list_len == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               idx = 0;
               while (idx < list_len && list_vals[idx] != key) idx++;
               if (idx >= list_len) begin
                  rsp.status = STATUS_NOT_FOUND;
               end else begin
                  // close the gap
                  for (int j = idx; j + 1 < list_len; j++) list_vals[j] = list_vals[j+1];
                  list_len--;
               end
            end
         end
         OP_READ: begin
            if (int'(req.position) >= list_len) begin
               rsp.status = STATUS_BAD_POS;
            end else begin
               rsp.read_value = list_vals[req.position];
            end
         end
         default: ;
      endcase
      rsp.count = list_len[COUNT_BITS-1:0];
      if (list_len > peak_len) peak_len = list_len;
      return rsp;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      error_count++;
   endtask

   task automatic push_req(input slir_opcode_type op, input logic [VALUE_BITS-1:0] val,
                           input logic [POS_BITS-1:0] pos);
      slir_req_type req;
      req.opcode   = op;
      req.value    = val;
      req.position = pos;
      pending_reqs.push_back(req);
   endtask

   // Random operations in alternating fill and drain runs, values mostly from a small pool
   task automatic push_random_ops(input int n);
      logic [VALUE_BITS-1:0] pool[8];
      logic                  filling;
      int                    roll;
      int                    ins_pct;
      int                    rem_pct;
      logic [VALUE_BITS-1:0] val;
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
      pool[2] = $urandom_range(20) - 10;
      pool[3] = $urandom_range(20) - 10;
      for (int k = 4; k < 8; k++) pool[k] = $urandom;
      filling = 1'($urandom_range(1));
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) filling = !filling;
         ins_pct = filling ? 58 : 22;
         rem_pct = filling ? 20 : 56;
         val = ($urandom_range(99) < 80) ? pool[3'($urandom_range(7))] : $urandom;
         roll = $urandom_range(99);
         if (roll < 4)
            push_req(OP_NONE, $urandom, POS_BITS'($urandom_range(15)));
         else if (roll < 4 + ins_pct)
            push_req(OP_INSERT, val, POS_BITS'($urandom_range(15)));
         else if (roll < 4 + ins_pct + rem_pct)
            push_req(OP_REMOVE, val, POS_BITS'($urandom_range(15)));
         else
            push_req(OP_READ, val, POS_BITS'($urandom_range(15)));
      end
   endtask

   // Hold until every queued transfer has been sent and answered
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   // Drive requests and predict each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_list_op(req_data));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check results and drive random back-pressure
   always @(posedge clock) begin : rsp_monitor
      slir_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected result %p", rsp_data));
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data.status !== exp_rsp.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, exp_rsp.status));
               if (rsp_data.read_value !== exp_rsp.read_value)
                  report_mismatch($sformatf("read_value %0d, want %0d",
                                            rsp_data.read_value, exp_rsp.read_value));
               if (rsp_data.count !== exp_rsp.count)
                  report_mismatch($sformatf("count %0d, want %0d",
                                            rsp_data.count, exp_rsp.count));
               if (exp_rsp.status <= STATUS_BAD_POS) status_seen[exp_rsp.status]++;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int idle_set[5];
      int stall_set[5];
      idle_set  = '{0, 71, 0, 24, 0};
      stall_set = '{0, 0, 71, 24, 0};
      foreach (status_seen[k]) status_seen[k] = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-list cases, extremes, duplicates, full list
      push_req(OP_READ, 32'd0, 4'd0);
      push_req(OP_REMOVE, 32'd5, 4'd0);
      push_req(OP_NONE, 32'hffff_ffff, 4'd15);
      push_req(OP_INSERT, 32'h7fff_ffff, 4'd0);
      push_req(OP_INSERT, 32'h8000_0000, 4'd15);
      push_req(OP_INSERT, 32'd0, 4'd0);
      push_req(OP_INSERT, 32'hffff_ffff, 4'd0);
      push_req(OP_INSERT, 32'd0, 4'd0);
      push_req(OP_REMOVE, 32'd123, 4'd0);
      push_req(OP_READ, 32'd0, 4'd0);
      push_req(OP_READ, 32'd0, 4'd4);
      push_req(OP_READ, 32'd0, 4'd5);
      for (int i = 0; i < 11; i++)
         push_req(OP_INSERT, $urandom, POS_BITS'($urandom_range(15)));
      push_req(OP_INSERT, 32'd77, 4'd0);
      push_req(OP_READ, 32'd0, 4'd15);
      push_req(OP_REMOVE, 32'd0, 4'd0);
      push_req(OP_REMOVE, 32'h8000_0000, 4'd0);
      wait_drained();

      // Random phases, each separated by a full drain
      for (int p = 0; p < 5; p++) begin
         idle_pct  = idle_set[p];
         stall_pct = stall_set[p];
         push_random_ops(160);
         wait_drained();
      end
      idle_pct  = 0;
      stall_pct = 0;
      repeat (DRAIN_WAIT) @(negedge clock);

      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));
      $display("Ran %0d operations; peak list size %0d of %0d", sent_count, peak_len,
               LIST_DEPTH);
      $display("Outcomes: %0d ok, %0d full, %0d empty, %0d not found, %0d bad position",
               status_seen[STATUS_OK], status_seen[STATUS_FULL], status_seen[STATUS_EMPTY],
               status_seen[STATUS_NOT_FOUND], status_seen[STATUS_BAD_POS]);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/slir_pkg.sv
sv/slir_cell.sv
sv/sorted_list_insert_remove_unit.sv
test/sorted_list_insert_remove_unit_tb.sv
